>>> sv/capacitor_companion_model_step_defines.svh
// Assertion macros for the capacitor companion model block.
`ifndef CAPACITOR_COMPANION_MODEL_STEP_DEFINES_SVH
`define CAPACITOR_COMPANION_MODEL_STEP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ccm_pkg.sv
// Types, constants and helpers shared by the capacitor companion model block.
`default_nettype none
package ccm_pkg;

  localparam int unsigned DW     = 32;      // Q16.16 word
  localparam int unsigned CW     = 31;      // coefficient width
  localparam int unsigned PW     = 64;      // exact product
  localparam int unsigned SW     = 66;      // sum before rounding
  localparam int unsigned RW     = SW - 16; // after rounding shift
  localparam int unsigned XW     = RW + 2;  // input of the saturator
  localparam int unsigned NSUSC  = 4;
  localparam int unsigned CFG_IW = 3;

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_PRE  = 2'd1,
    MODE_POST = 2'd2,
    MODE_HOLD = 2'd3
  } mode_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_COND_REAL = 3'd0,
    CFG_SUSC_0    = 3'd1,
    CFG_SUSC_1    = 3'd2,
    CFG_SUSC_2    = 3'd3,
    CFG_SUSC_3    = 3'd4,
    CFG_NODE0_GND = 3'd5,
    CFG_NODE1_GND = 3'd6
  } cfg_idx_e;

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    word_t re;
    word_t im;
  } cplx_t;

  typedef struct packed {
    cplx_t ieq;
    cplx_t cur;
    cplx_t volt;
  } entry_t;

  typedef struct packed {
    logic [CW-1:0]            cond;
    logic [NSUSC-1:0][CW-1:0] susc;
    logic                     node0_gnd;
    logic                     node1_gnd;
  } cfg_t;

  // item as captured at the input
  typedef struct packed {
    logic       valid;
    logic       inr;
    mode_e      mode;
    logic [1:0] harm;
    cplx_t      a;
    cplx_t      b;
    cplx_t      vdiff;
  } item_t;

  typedef struct packed {
    logic [1:0] harm;
    entry_t     e;
  } res_t;

  typedef struct packed {
    logic wr_en;
    logic s3_valid;
  } core_stat_t;

  function automatic word_t sat_word(input logic signed [XW-1:0] x);
    logic [XW-DW:0] hi;
    hi = x[XW-1:DW-1];
    if (hi == '0 || hi == '1) begin
      return x[DW-1:0];
    end else if (x[XW-1]) begin
      return {1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

>>> sv/ccm_in_if.sv
// Input stream channel: valid/ready plus one input item.
`default_nettype none
interface ccm_in_if import ccm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] harmonic;
  word_t      value_a_re;
  word_t      value_a_im;
  word_t      value_b_re;
  word_t      value_b_im;

  modport source (
    output valid, mode, harmonic, value_a_re, value_a_im, value_b_re, value_b_im,
    input  ready
  );
  modport sink (
    input  valid, mode, harmonic, value_a_re, value_a_im, value_b_re, value_b_im,
    output ready
  );
endinterface
`default_nettype wire

>>> sv/ccm_out_if.sv
// Output stream channel: valid/ready plus one result item.
`default_nettype none
interface ccm_out_if import ccm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] harmonic_out;
  word_t      inject_re;
  word_t      inject_im;
  word_t      volt_re;
  word_t      volt_im;
  word_t      cur_re;
  word_t      cur_im;

  modport source (
    output valid, harmonic_out, inject_re, inject_im, volt_re, volt_im, cur_re, cur_im,
    input  ready
  );
  modport sink (
    input  valid, harmonic_out, inject_re, inject_im, volt_re, volt_im, cur_re, cur_im,
    output ready
  );
endinterface
`default_nettype wire

>>> sv/ccm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ccm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-first: a same-edge write is not seen
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> sv/ccm_cfg.sv
// Configuration register file: conductance, susceptances, ground flags.
`default_nettype none
module ccm_cfg import ccm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [CFG_IW-1:0] idx_i,
  input  logic [CW-1:0]     data_i,
  output cfg_t              cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_COND_REAL: cfg_d.cond      = data_i;
        CFG_SUSC_0:    cfg_d.susc[0]   = data_i;
        CFG_SUSC_1:    cfg_d.susc[1]   = data_i;
        CFG_SUSC_2:    cfg_d.susc[2]   = data_i;
        CFG_SUSC_3:    cfg_d.susc[3]   = data_i;
        CFG_NODE0_GND: cfg_d.node0_gnd = data_i[0];
        CFG_NODE1_GND: cfg_d.node1_gnd = data_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> sv/ccm_core.sv
// Read-modify-write pipeline around the per-harmonic state RAM.
`default_nettype none
module ccm_core import ccm_pkg::*; #(
  parameter int unsigned HARMONICS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  item_t      item_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output res_t       res_o,
  output core_stat_t stat_o
);

  localparam int unsigned AW    = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
  localparam int unsigned NHIST = 3;  // writes a read can miss

  typedef struct packed {
    mode_e                mode;
    logic [1:0]           harm;
    logic                 inr;
    cplx_t                volt;
    cplx_t                cur_in;
    cplx_t                cur_st;
    cplx_t                ieq_st;
    logic signed [PW-1:0] p_gvr;
    logic signed [PW-1:0] p_gvi;
    logic signed [PW-1:0] p_bvr;
    logic signed [PW-1:0] p_bvi;
  } s2_t;

  typedef struct packed {
    mode_e                mode;
    logic [1:0]           harm;
    logic                 inr;
    cplx_t                volt;
    cplx_t                cur_st;
    cplx_t                ieq_st;
    cplx_t                ieq0;
    logic signed [RW-1:0] g_re;
    logic signed [RW-1:0] g_im;
    logic signed [RW-1:0] n_re;
    logic signed [RW-1:0] n_im;
  } s3_t;

  // ---------------- pipeline registers
  logic  s1_v_q, s2_v_q, s3_v_q;
  item_t s1_q;
  s2_t   s2_q, s2_d;
  s3_t   s3_q, s3_d;
  logic  hv_q [NHIST];
  res_t  hd_q [NHIST];

  // ---------------- state RAM and entry valid bits
  logic [HARMONICS-1:0] evld_q;
  logic                 ev_rd;
  logic                 s1_ev_q;
  entry_t               rdata;
  entry_t               wdata;
  logic                 wr_en;

  ccm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (HARMONICS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (adv_i),
    .we_i    (wr_en),
    .waddr_i (s3_q.harm[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (item_i.harm[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    ev_rd = 1'b0;
    for (int i = 0; i < HARMONICS; i++) begin
      if (item_i.harm[AW-1:0] == AW'(i)) begin
        ev_rd = evld_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evld_q <= '0;
    end else begin
      for (int i = 0; i < HARMONICS; i++) begin
        if (wr_en && s3_q.harm[AW-1:0] == AW'(i)) begin
          evld_q[i] <= 1'b1;
        end
      end
    end
  end

  // ---------------- stage 1: forward V, multiply
  entry_t               st1;
  cplx_t                v_fwd, v_sel;
  logic signed [DW-1:0] gs, bs;

  always_comb begin
    st1   = s1_ev_q ? rdata : '0;
    v_fwd = st1.volt;
    if (hv_q[0] && hd_q[0].harm == s1_q.harm) v_fwd = hd_q[0].e.volt;
    if (s3_v_q && s3_q.inr && s3_q.harm == s1_q.harm) v_fwd = s3_q.volt;
    if (s2_v_q && s2_q.inr && s2_q.harm == s1_q.harm) v_fwd = s2_q.volt;
    case (s1_q.mode)
      MODE_INIT: v_sel = s1_q.a;
      MODE_POST: v_sel = s1_q.vdiff;
      default:   v_sel = v_fwd;
    endcase
    gs = $signed({1'b0, cfg_i.cond});
    bs = $signed({1'b0, cfg_i.susc[s1_q.harm]});

    s2_d.mode   = s1_q.mode;
    s2_d.harm   = s1_q.harm;
    s2_d.inr    = s1_q.inr;
    s2_d.volt   = v_sel;
    s2_d.cur_in = s1_q.b;
    s2_d.cur_st = st1.cur;
    s2_d.ieq_st = st1.ieq;
    s2_d.p_gvr  = gs * $signed(v_sel.re);
    s2_d.p_gvi  = gs * $signed(v_sel.im);
    s2_d.p_bvr  = bs * $signed(v_sel.re);
    s2_d.p_bvi  = bs * $signed(v_sel.im);
  end

  // ---------------- stage 2: complex sums and rounding
  // n_* is -(init current) - round(P*V), folded into one floor shift
  logic signed [SW-1:0] sum_gre, sum_gim, sum_nre, sum_nim, bsh_re, bsh_im;

  always_comb begin
    bsh_re = '0;
    bsh_im = '0;
    if (s2_q.mode == MODE_INIT) begin
      bsh_re = SW'($signed(s2_q.cur_in.re)) <<< 16;
      bsh_im = SW'($signed(s2_q.cur_in.im)) <<< 16;
    end
    sum_gre = SW'($signed(s2_q.p_gvr)) - SW'($signed(s2_q.p_bvi)) + SW'(32768);
    sum_gim = SW'($signed(s2_q.p_gvi)) + SW'($signed(s2_q.p_bvr)) + SW'(32768);
    sum_nre = -SW'($signed(s2_q.p_gvr)) - SW'($signed(s2_q.p_bvi)) - bsh_re + SW'(32767);
    sum_nim = -SW'($signed(s2_q.p_gvi)) + SW'($signed(s2_q.p_bvr)) - bsh_im + SW'(32767);

    s3_d.mode    = s2_q.mode;
    s3_d.harm    = s2_q.harm;
    s3_d.inr     = s2_q.inr;
    s3_d.volt    = s2_q.volt;
    s3_d.cur_st  = s2_q.cur_st;
    s3_d.ieq_st  = s2_q.ieq_st;
    s3_d.g_re    = RW'(sum_gre >>> 16);
    s3_d.g_im    = RW'(sum_gim >>> 16);
    s3_d.n_re    = RW'(sum_nre >>> 16);
    s3_d.n_im    = RW'(sum_nim >>> 16);
    s3_d.ieq0.re = sat_word(XW'($signed(s3_d.n_re)));
    s3_d.ieq0.im = sat_word(XW'($signed(s3_d.n_im)));
  end

  // ---------------- stage 3: resolve stored I/Ieq, update, write back
  cplx_t cur_r, ieq_r, ieq_add;
  entry_t upd;

  always_comb begin
    cur_r = s3_q.cur_st;
    ieq_r = s3_q.ieq_st;
    for (int k = NHIST - 1; k >= 0; k--) begin
      if (hv_q[k] && hd_q[k].harm == s3_q.harm) begin
        cur_r = hd_q[k].e.cur;
        ieq_r = hd_q[k].e.ieq;
      end
    end
    ieq_add  = (s3_q.mode == MODE_INIT) ? s3_q.ieq0 : ieq_r;
    upd.volt = s3_q.volt;
    upd.cur  = cur_r;
    upd.ieq  = ieq_r;
    case (s3_q.mode)
      MODE_INIT: begin
        upd.ieq = s3_q.ieq0;
      end
      MODE_PRE: begin
        upd.ieq.re = sat_word(XW'($signed(s3_q.n_re)) - XW'($signed(cur_r.re)));
        upd.ieq.im = sat_word(XW'($signed(s3_q.n_im)) - XW'($signed(cur_r.im)));
      end
      default: ;
    endcase
    if (s3_q.mode == MODE_INIT || s3_q.mode == MODE_POST) begin
      upd.cur.re = sat_word(XW'($signed(s3_q.g_re)) + XW'($signed(ieq_add.re)));
      upd.cur.im = sat_word(XW'($signed(s3_q.g_im)) + XW'($signed(ieq_add.im)));
    end
  end

  assign wdata = upd;
  assign wr_en = adv_i && s3_v_q && s3_q.inr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      for (int k = 0; k < NHIST; k++) hv_q[k] <= 1'b0;
    end else if (adv_i) begin
      s1_v_q  <= item_i.valid;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      hv_q[0] <= s3_v_q && s3_q.inr;
      for (int k = 1; k < NHIST; k++) hv_q[k] <= hv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q    <= item_i;
      s1_ev_q <= ev_rd;
      s2_q    <= s2_d;
      s3_q    <= s3_d;
      hd_q[0] <= '{harm: s3_q.harm, e: upd};
      for (int k = 1; k < NHIST; k++) hd_q[k] <= hd_q[k-1];
    end
  end

  assign res_valid_o     = s3_v_q;
  assign res_o.harm      = s3_q.harm;
  assign res_o.e         = s3_q.inr ? upd : '0;
  assign stat_o.wr_en    = wr_en;
  assign stat_o.s3_valid = s3_v_q;

endmodule
`default_nettype wire

>>> sv/capacitor_companion_model_step.sv
// Top level of the trapezoidal capacitor companion model, dynamic-phasor form.
//
// One transaction per clock cycle in sustained flow; an accepted item passes the
// stage 1, 2 and 3 registers and then the output register. State lives in one RAM
// entry per harmonic that is read on accept and written back from stage 3; the single
// read and write port of that RAM sets the rate, and forwarding from the stages in
// flight and the last three writes keeps back-to-back items on the same harmonic
// exact. The whole pipeline holds while a result waits in the output register and
// the sink is not ready. State reads as zero after reset through per-entry valid
// bits, so no clearing pass is needed. Configuration writes take effect at once.
`default_nettype none
`include "capacitor_companion_model_step_defines.svh"
module capacitor_companion_model_step import ccm_pkg::*; #(
  parameter int unsigned HARMONICS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ccm_in_if.sink            in_i,
  ccm_out_if.source         out_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CW-1:0]     cfg_data_i
);

  cfg_t       cfg;
  item_t      item;
  logic       adv;
  logic       res_valid;
  res_t       res;
  core_stat_t stat;
  logic       out_v_q;
  res_t       out_q;
  word_t      v1_re, v1_im, v0_re, v0_im;

  ccm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // pipeline moves whenever the output register can take a result
  assign adv        = !out_v_q || out_o.ready;
  assign in_i.ready = adv;

  always_comb begin
    v1_re = cfg.node1_gnd ? '0 : in_i.value_a_re;
    v1_im = cfg.node1_gnd ? '0 : in_i.value_a_im;
    v0_re = cfg.node0_gnd ? '0 : in_i.value_b_re;
    v0_im = cfg.node0_gnd ? '0 : in_i.value_b_im;
    item.valid    = in_i.valid;
    item.inr      = 32'(in_i.harmonic) < HARMONICS;
    item.mode     = mode_e'(in_i.mode);
    item.harm     = in_i.harmonic;
    item.a.re     = in_i.value_a_re;
    item.a.im     = in_i.value_a_im;
    item.b.re     = in_i.value_b_re;
    item.b.im     = in_i.value_b_im;
    item.vdiff.re = sat_word(XW'($signed(v1_re)) - XW'($signed(v0_re)));
    item.vdiff.im = sat_word(XW'($signed(v1_im)) - XW'($signed(v0_im)));
  end

  ccm_core #(
    .HARMONICS (HARMONICS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .item_i      (item),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res),
    .stat_o      (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.harmonic_out = out_q.harm;
  assign out_o.inject_re    = out_q.e.ieq.re;
  assign out_o.inject_im    = out_q.e.ieq.im;
  assign out_o.volt_re      = out_q.e.volt.re;
  assign out_o.volt_im      = out_q.e.volt.im;
  assign out_o.cur_re       = out_q.e.cur.re;
  assign out_o.cur_im       = out_q.e.cur.im;

  // state is only written when the pipeline moves
  `CCM_ASSERT_IMP(a_wr_on_adv, stat.wr_en, adv, "state write while pipeline held")
  // a finished item lands in the output register
  `CCM_ASSERT_NXT(a_out_load, adv && stat.s3_valid, out_v_q, "result lost at output")
  // harmonics beyond the configured count report zeros
  `CCM_ASSERT_IMP(a_range_zero, out_v_q && (32'(out_q.harm) >= HARMONICS), out_q.e == '0,
                  "nonzero result for unused harmonic")

endmodule
`default_nettype wire

>>> sim/capacitor_companion_model_step_tb.sv
// Self-checking testbench: directed and random phasor items against a built-in branch predictor.
`timescale 1ns / 100ps
module capacitor_companion_model_step_tb;
  import ccm_pkg::*;

  localparam int unsigned NHARM          = 4;
  localparam int unsigned CYCLE_LIMIT    = 300000;
  localparam int unsigned RX_HOLD        = 64;
  localparam int unsigned DRAIN_WAIT     = 8;
  localparam int unsigned RAND_PER_PHASE = 84;
  localparam int unsigned NPHASE         = 6;
  localparam int unsigned MAX_PRINTS     = 40;

  typedef logic signed [65:0] wide_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam wide_t WIDE_MAX = 66'sd2147483647;
  localparam wide_t WIDE_MIN = -66'sd2147483648;
  localparam logic [CW-1:0] COEF_MAX = '1;

  typedef struct packed {
    logic       is_cfg;
    cfg_t       cfg;
    mode_e      mode;
    logic [1:0] harm;
    cplx_t      a;
    cplx_t      b;
    logic       typed;
    res_t       want;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CW-1:0]     cfg_data;

  ccm_in_if  in_if ();
  ccm_out_if out_if ();

  capacitor_companion_model_step u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state and its copy of the registers
  cplx_t br_volt  [NHARM];
  cplx_t br_cur   [NHARM];
  cplx_t hist_cur [NHARM];
  cfg_t  mdl_cfg;
  res_t  branch_q [$];

  // directed stimulus table
  dir_row_t dir_rows [$];

  // typed expectation that travels with the item on the channel
  logic  row_typed;
  res_t  row_want;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int          n_sent = 0;
  int          hold_reqs = 0;
  int          holds_done = 0;
  bit          calm = 1'b0;
  bit          inited [NHARM];

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic wide_t sx(input word_t w);
    return w;
  endfunction

  // Q32.32 -> Q16.16, round half up, floor shift
  function automatic wide_t round_q16(input wide_t x);
    return (x + 66'sd32768) >>> 16;
  endfunction

  function automatic word_t clamp_word(input wide_t x);
    if (x > WIDE_MAX) return WORD_MAX;
    if (x < WIDE_MIN) return WORD_MIN;
    return x[31:0];
  endfunction

  // (g + j*b) * v, or (g - j*b) * v when conj is set
  function automatic void phasor_mul(input logic [CW-1:0] g, input logic [CW-1:0] b,
                                     input bit conj, input cplx_t v,
                                     output wide_t pr, output wide_t pim);
    wide_t gg, bb, vr, vi;
    gg = $signed({35'd0, g});
    bb = $signed({35'd0, b});
    if (conj) bb = -bb;
    vr = sx(v.re);
    vi = sx(v.im);
    pr  = round_q16(gg * vr - bb * vi);
    pim = round_q16(gg * vi + bb * vr);
  endfunction

  function automatic void update_history(input logic [1:0] h);
    wide_t pr, pim;
    phasor_mul(mdl_cfg.cond, mdl_cfg.susc[h], 1'b1, br_volt[h], pr, pim);
    hist_cur[h].re = clamp_word(-sx(br_cur[h].re) - pr);
    hist_cur[h].im = clamp_word(-sx(br_cur[h].im) - pim);
  endfunction

  function automatic void update_current(input logic [1:0] h);
    wide_t pr, pim;
    phasor_mul(mdl_cfg.cond, mdl_cfg.susc[h], 1'b0, br_volt[h], pr, pim);
    br_cur[h].re = clamp_word(pr + sx(hist_cur[h].re));
    br_cur[h].im = clamp_word(pim + sx(hist_cur[h].im));
  endfunction

  // harmonic field is 2 bits wide and NHARM is 4, so no out-of-range index exists
  function automatic res_t predict_branch(input logic [1:0] mode, input logic [1:0] h,
                                          input cplx_t a, input cplx_t b);
    res_t  r;
    cplx_t v1, v0;
    case (mode_e'(mode))
      MODE_INIT: begin
        br_volt[h] = a;
        br_cur[h]  = b;
        update_history(h);
        update_current(h);
      end
      MODE_PRE: begin
        update_history(h);
      end
      MODE_POST: begin
        v1 = mdl_cfg.node1_gnd ? '0 : a;
        v0 = mdl_cfg.node0_gnd ? '0 : b;
        br_volt[h].re = clamp_word(sx(v1.re) - sx(v0.re));
        br_volt[h].im = clamp_word(sx(v1.im) - sx(v0.im));
        update_current(h);
      end
      default: ;
    endcase
    r.harm   = h;
    r.e.ieq  = hist_cur[h];
    r.e.cur  = br_cur[h];
    r.e.volt = br_volt[h];
    return r;
  endfunction

  function automatic cplx_t mkc(input word_t re, input word_t im);
    cplx_t c;
    c.re = re;
    c.im = im;
    return c;
  endfunction

  function automatic res_t mk_res(input logic [1:0] h, input cplx_t ieq, input cplx_t volt,
                                  input cplx_t cur);
    res_t r;
    r.harm   = h;
    r.e.ieq  = ieq;
    r.e.volt = volt;
    r.e.cur  = cur;
    return r;
  endfunction

  function automatic cfg_t mk_cfg(input logic [CW-1:0] cond, input logic [CW-1:0] s0,
                                  input logic [CW-1:0] s1, input logic [CW-1:0] s2,
                                  input logic [CW-1:0] s3, input logic gnd0, input logic gnd1);
    cfg_t c;
    c.cond      = cond;
    c.susc[0]   = s0;
    c.susc[1]   = s1;
    c.susc[2]   = s2;
    c.susc[3]   = s3;
    c.node0_gnd = gnd0;
    c.node1_gnd = gnd1;
    return c;
  endfunction

  function automatic dir_row_t mk_item(input mode_e m, input logic [1:0] h, input cplx_t a,
                                       input cplx_t b, input logic typed, input res_t want);
    dir_row_t r;
    r        = '0;
    r.mode   = m;
    r.harm   = h;
    r.a      = a;
    r.b      = b;
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  function automatic dir_row_t mk_cfg_row(input cfg_t c);
    dir_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.cfg    = c;
    return r;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return word_t'($urandom_range(0, 2)) - 32'sd1;
      3, 4, 5: return $urandom;
      default: return word_t'($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_coef();
    logic [31:0] r;
    case ($urandom_range(0, 7))
      0: r = '0;
      1: r = {1'b0, COEF_MAX};
      2, 3: r = $urandom;
      default: r = $urandom_range(0, 32'h8_0000);
    endcase
    return r[CW-1:0];
  endfunction

  // register writes and transactions seen by the block at this edge
  always @(posedge clk_i) begin : accept_mon
    res_t want;
    if (cfg_we) begin
      case (cfg_idx_e'(cfg_idx))
        CFG_COND_REAL: mdl_cfg.cond      = cfg_data;
        CFG_SUSC_0:    mdl_cfg.susc[0]   = cfg_data;
        CFG_SUSC_1:    mdl_cfg.susc[1]   = cfg_data;
        CFG_SUSC_2:    mdl_cfg.susc[2]   = cfg_data;
        CFG_SUSC_3:    mdl_cfg.susc[3]   = cfg_data;
        CFG_NODE0_GND: mdl_cfg.node0_gnd = cfg_data[0];
        CFG_NODE1_GND: mdl_cfg.node1_gnd = cfg_data[0];
        default: ;
      endcase
    end
    if (in_if.valid && in_if.ready) begin
      want = predict_branch(in_if.mode, in_if.harmonic,
                            mkc(in_if.value_a_re, in_if.value_a_im),
                            mkc(in_if.value_b_re, in_if.value_b_im));
      if (row_typed) want = row_want;
      branch_q.insert(branch_q.size(), want);
    end
  end

  task automatic compare_word(input string name, input word_t got, input word_t want);
    if (got !== want)
      report_mismatch($sformatf("%s got %08h expected %08h", name, got, want));
  endtask

  always @(posedge clk_i) begin : result_mon
    res_t want;
    if (out_if.valid && out_if.ready) begin
      if (branch_q.size() == 0) begin
        report_mismatch($sformatf("result for harmonic %0d with nothing pending",
                                  out_if.harmonic_out));
      end else begin
        want = branch_q.pop_front();
        if (out_if.harmonic_out !== want.harm)
          report_mismatch($sformatf("harmonic_out got %0d expected %0d",
                                    out_if.harmonic_out, want.harm));
        compare_word("inject_re", out_if.inject_re, want.e.ieq.re);
        compare_word("inject_im", out_if.inject_im, want.e.ieq.im);
        compare_word("volt_re",   out_if.volt_re,   want.e.volt.re);
        compare_word("volt_im",   out_if.volt_im,   want.e.volt.im);
        compare_word("cur_re",    out_if.cur_re,    want.e.cur.re);
        compare_word("cur_im",    out_if.cur_im,    want.e.cur.im);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // sink side: random stalls, forced long hold-offs, always ready at the end
  initial begin : rx_side
    int n;
    out_if.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (holds_done != hold_reqs) begin
        holds_done++;
        out_if.ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk_i);
      end else if (calm) begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 18);
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        n = $urandom_range(1, 20);
        out_if.ready <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // returns in the step right after the accepting edge; valid stays high
  task automatic send_item(input mode_e m, input logic [1:0] h, input cplx_t a,
                           input cplx_t b, input logic typed, input res_t want);
    in_if.valid      <= 1'b1;
    in_if.mode       <= m;
    in_if.harmonic   <= h;
    in_if.value_a_re <= a.re;
    in_if.value_a_im <= a.im;
    in_if.value_b_re <= b.re;
    in_if.value_b_im <= b.im;
    row_typed        <= typed;
    row_want         <= want;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic idle_gap();
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 18);
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (branch_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic load_config(input cfg_t c);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_COND_REAL;
    cfg_data <= c.cond;
    @(posedge clk_i);
    for (int i = 0; i < NSUSC; i++) begin
      cfg_idx  <= CFG_SUSC_0 + 3'(i);
      cfg_data <= c.susc[i];
      @(posedge clk_i);
    end
    cfg_idx  <= CFG_NODE0_GND;
    cfg_data <= {{(CW-1){1'b0}}, c.node0_gnd};
    @(posedge clk_i);
    cfg_idx  <= CFG_NODE1_GND;
    cfg_data <= {{(CW-1){1'b0}}, c.node1_gnd};
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic random_item(input mode_e m, input logic [1:0] h);
    send_item(m, h, mkc(rand_word(), rand_word()), mkc(rand_word(), rand_word()), 1'b0, '0);
    idle_gap();
  endtask

  // mostly init / pre / post sequences per harmonic, some noise and broken order
  task automatic random_phase(input int n_items);
    int         start;
    int         pairs;
    logic [1:0] h, h2;
    start = n_sent;
    while (n_sent - start < n_items) begin
      h  = 2'($urandom_range(0, NHARM - 1));
      h2 = 2'($urandom_range(0, NHARM - 1));
      case ($urandom_range(0, 9))
        0, 1: random_item(mode_e'($urandom_range(0, 3)), h);
        2: begin
          random_item(MODE_PRE, h);
          random_item(MODE_PRE, h);
          random_item(MODE_POST, h);
          random_item(MODE_POST, h);
        end
        3: begin
          random_item(MODE_PRE, h);
          random_item(MODE_PRE, h2);
          random_item(MODE_POST, h);
          random_item(MODE_POST, h2);
        end
        default: begin
          if (!inited[h] || $urandom_range(0, 7) == 0) begin
            random_item(MODE_INIT, h);
            inited[h] = 1'b1;
          end
          pairs = $urandom_range(1, 6);
          repeat (pairs) begin
            random_item(MODE_PRE, h);
            random_item(MODE_POST, h);
            if ($urandom_range(0, 7) == 0) random_item(MODE_HOLD, h);
          end
        end
      endcase
    end
  endtask

  initial begin : stim
    dir_row_t row;
    cfg_t     c;
    cplx_t    zero;

    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.mode       = '0;
    in_if.harmonic   = '0;
    in_if.value_a_re = '0;
    in_if.value_a_im = '0;
    in_if.value_b_re = '0;
    in_if.value_b_im = '0;
    row_typed        = 1'b0;
    row_want         = '0;
    mdl_cfg          = '0;
    zero             = '0;
    for (int i = 0; i < NHARM; i++) begin
      br_volt[i]  = '0;
      br_cur[i]   = '0;
      hist_cur[i] = '0;
      inited[i]   = 1'b0;
    end

    // with all coefficients zero after reset: Ieq = -I and I = Ieq
    add_row(mk_item(MODE_HOLD, 2'd0, zero, zero, 1'b1,
                    mk_res(2'd0, zero, zero, zero)));
    add_row(mk_item(MODE_INIT, 2'd0, mkc(WORD_MAX, WORD_MIN), mkc(WORD_MIN, WORD_MAX),
                    1'b1, mk_res(2'd0, mkc(WORD_MAX, 32'sh8000_0001),
                                 mkc(WORD_MAX, WORD_MIN),
                                 mkc(WORD_MAX, 32'sh8000_0001))));
    add_row(mk_item(MODE_INIT, 2'd1, mkc(32'sd1, -32'sd1), zero, 1'b1,
                    mk_res(2'd1, zero, mkc(32'sd1, -32'sd1), zero)));
    add_row(mk_item(MODE_PRE, 2'd0, zero, zero, 1'b1,
                    mk_res(2'd0, mkc(32'sh8000_0001, WORD_MAX),
                           mkc(WORD_MAX, WORD_MIN),
                           mkc(WORD_MAX, 32'sh8000_0001))));
    // post-step with no prior pre-step; voltage difference saturates both ways
    add_row(mk_item(MODE_POST, 2'd2, mkc(WORD_MAX, WORD_MIN), mkc(WORD_MIN, WORD_MAX),
                    1'b1, mk_res(2'd2, zero, mkc(WORD_MAX, WORD_MIN), zero)));
    add_row(mk_item(MODE_POST, 2'd3, mkc(WORD_MIN, 32'sd5), mkc(32'sd1, 32'sd5),
                    1'b1, mk_res(2'd3, zero, mkc(WORD_MIN, 32'sd0), zero)));
    add_row(mk_item(MODE_HOLD, 2'd1, mkc(WORD_MAX, WORD_MAX), mkc(WORD_MIN, WORD_MIN),
                    1'b1, mk_res(2'd1, zero, mkc(32'sd1, -32'sd1), zero)));

    // g = 1.0, B0 = 0.5 gives exact half-LSB products for odd voltages
    add_row(mk_cfg_row(mk_cfg(31'h1_0000, 31'h8000, COEF_MAX, 31'd1, 31'h1_8000,
                              1'b0, 1'b0)));
    add_row(mk_item(MODE_INIT, 2'd0, mkc(32'sd1, -32'sd1), zero, 1'b0, '0));
    add_row(mk_item(MODE_INIT, 2'd0, mkc(32'sd3, -32'sd3),
                    mkc(32'sh1234, -32'sh5678), 1'b0, '0));
    add_row(mk_item(MODE_PRE, 2'd0, zero, zero, 1'b0, '0));
    add_row(mk_item(MODE_POST, 2'd0, mkc(32'sh3_0000, -32'sh8000),
                    mkc(32'sh1_0000, 32'sh4000), 1'b0, '0));
    add_row(mk_item(MODE_PRE, 2'd0, zero, zero, 1'b0, '0));
    add_row(mk_item(MODE_POST, 2'd1, mkc(WORD_MAX, WORD_MAX), mkc(WORD_MIN, WORD_MIN),
                    1'b0, '0));
    add_row(mk_item(MODE_HOLD, 2'd0, zero, zero, 1'b0, '0));

    // both terminals grounded, largest coefficients
    add_row(mk_cfg_row(mk_cfg(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                              1'b1, 1'b1)));
    add_row(mk_item(MODE_POST, 2'd2, mkc(WORD_MAX, WORD_MIN), mkc(32'sd1, 32'sd2),
                    1'b0, '0));
    add_row(mk_item(MODE_INIT, 2'd3, mkc(WORD_MAX, WORD_MIN), mkc(WORD_MIN, WORD_MIN),
                    1'b0, '0));
    add_row(mk_item(MODE_PRE, 2'd3, zero, zero, 1'b0, '0));
    add_row(mk_item(MODE_POST, 2'd3, mkc(32'sh7_1234, -32'sh2_0001), zero, 1'b0, '0));

    add_row(mk_cfg_row(mk_cfg(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                              1'b1, 1'b0)));
    add_row(mk_item(MODE_POST, 2'd0, mkc(WORD_MIN, WORD_MAX), mkc(WORD_MAX, WORD_MAX),
                    1'b0, '0));
    add_row(mk_item(MODE_PRE, 2'd0, zero, zero, 1'b0, '0));

    add_row(mk_cfg_row(mk_cfg(COEF_MAX, '0, '0, '0, '0, 1'b0, 1'b1)));
    add_row(mk_item(MODE_POST, 2'd1, mkc(WORD_MAX, WORD_MAX), mkc(WORD_MIN, 32'sd1),
                    1'b0, '0));
    add_row(mk_item(MODE_PRE, 2'd1, zero, zero, 1'b0, '0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        load_config(row.cfg);
      end else begin
        send_item(row.mode, row.harm, row.a, row.b, row.typed, row.want);
        idle_gap();
      end
    end

    for (int p = 0; p < NPHASE; p++) begin
      case (p)
        0: c = mk_cfg(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b0, 1'b0);
        1: c = mk_cfg(CW'($urandom_range(1, 32'h4_0000)), CW'($urandom_range(0, 32'h4_0000)),
                      CW'($urandom_range(0, 32'h4_0000)), CW'($urandom_range(0, 32'h4_0000)),
                      CW'($urandom_range(0, 32'h4_0000)), 1'b1, 1'b0);
        2: c = mk_cfg(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                      1'b0, 1'b1);
        3: c = mk_cfg(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                      1'b1, 1'b1);
        4: c = mk_cfg('0, rand_coef(), rand_coef(), rand_coef(), rand_coef(), 1'b0, 1'b0);
        default: c = mk_cfg(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                            1'b0, 1'b0);
      endcase
      load_config(c);
      if (p == NPHASE - 1) calm = 1'b1;
      // long sink hold-off while items keep coming, so the input backs up
      if (p == 1) hold_reqs++;
      if (p == 2) begin
        random_phase(RAND_PER_PHASE / 2);
        drain_results();
        random_phase(RAND_PER_PHASE / 2);
      end else begin
        random_phase(RAND_PER_PHASE);
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/ccm_pkg.sv
sv/ccm_in_if.sv
sv/ccm_out_if.sv
sv/ccm_ram.sv
sv/ccm_cfg.sv
sv/ccm_core.sv
sv/capacitor_companion_model_step.sv
sim/capacitor_companion_model_step_tb.sv
